FILE: hdl/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and constants for the planar frame rotator
// cordic angle table, gain and stage counts, pipeline stage enables
// ----------------------------------------------------------------------------
package pfr_pkg;

  // cordic datapath in q2.30, phase in 32-bit binary angle units
  localparam int CordicStages = 30;
  localparam int CordicWidth  = 32;
  localparam int PhaseWidth   = 32;
  localparam logic signed [CordicWidth-1:0] CordicGain = 32'sd652032874;

  // coordinate split for the partial products
  localparam int SplitBits = 24;
  // total register stages: input, cordic, map, multiply, add, saturate
  localparam int PipeDepth = CordicStages + 5;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic mul;
    logic add;
    logic sat;
  } dot_en_t;

  // atan(2^-i) in phase units, full turn = 2^32
  function automatic logic signed [CordicWidth-1:0] atan_lut(input logic [4:0] idx);
    logic signed [CordicWidth-1:0] a;
    case (idx)
      5'd0:    a = 32'sd536870912;
      5'd1:    a = 32'sd316933406;
      5'd2:    a = 32'sd167458907;
      5'd3:    a = 32'sd85004756;
      5'd4:    a = 32'sd42667331;
      5'd5:    a = 32'sd21354465;
      5'd6:    a = 32'sd10679838;
      5'd7:    a = 32'sd5340245;
      5'd8:    a = 32'sd2670163;
      5'd9:    a = 32'sd1335087;
      5'd10:   a = 32'sd667544;
      5'd11:   a = 32'sd333772;
      5'd12:   a = 32'sd166886;
      5'd13:   a = 32'sd83443;
      5'd14:   a = 32'sd41722;
      5'd15:   a = 32'sd20861;
      5'd16:   a = 32'sd10430;
      5'd17:   a = 32'sd5215;
      5'd18:   a = 32'sd2608;
      5'd19:   a = 32'sd1304;
      5'd20:   a = 32'sd652;
      5'd21:   a = 32'sd326;
      5'd22:   a = 32'sd163;
      5'd23:   a = 32'sd81;
      5'd24:   a = 32'sd41;
      5'd25:   a = 32'sd20;
      5'd26:   a = 32'sd10;
      5'd27:   a = 32'sd5;
      5'd28:   a = 32'sd3;
      5'd29:   a = 32'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/planar_frame_rotation.sv
// ----------------------------------------------------------------------------
// planar_frame_rotation: rotate a 2d point between world and body frames
// pipelined cordic sine/cosine followed by a rounded, saturated 2x2 product
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit first)               tuser
//  s_axis   in   x_in, y_in, heading                 action
//  m_axis   out  x_out, y_out                        clipped
//
// one beat per cycle sustained while m_axis_tready stays high; one input stage,
// 30 cordic stages, a quadrant map, a multiply, an add and a clamp stage
// every stage carries a valid bit; a stalled output only freezes the stages
// up to the first empty one, so bubbles are squeezed out and beats keep
// entering while a finished result waits
// reset clears the valid bits only; no clearing pass
//
module planar_frame_rotation #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // x_in, y_in, heading
  input  logic [((2*COORD_BITS+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // x_out, y_out
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // clipped
  output logic                m_axis_tuser
);

  localparam int NS   = pfr_pkg::PipeDepth;
  localparam int NC   = pfr_pkg::CordicStages;
  localparam int CW   = pfr_pkg::CordicWidth;
  localparam int MAP  = NC + 1;
  localparam int MUL  = NC + 2;
  localparam int ADD  = NC + 3;
  localparam int SAT  = NC + 4;
  localparam int OUTW = ((2*COORD_BITS+7)/8)*8;
  localparam logic signed [COORD_BITS-1:0] MaxVal = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] MinVal = {1'b1, {(COORD_BITS-1){1'b0}}};
  // cordic output magnitude stays near unity in q2.30
  localparam logic signed [CW-1:0] UnitBound = 32'sd1073741888;

  // per-stage valid and enable chain
  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  assign en[NS] = m_axis_tready;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // input stage: heading to 32-bit phase, fold residual into +/- 1/8 turn
  logic [pfr_pkg::PhaseWidth-1:0] phase;
  logic signed [COORD_BITS-1:0]   x_in, y_in;
  logic signed [CW-1:0]           z0_d;
  pfr_pkg::quad_e                 q0_d;

  assign x_in  = s_axis_tdata[COORD_BITS-1:0];
  assign y_in  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign phase = {s_axis_tdata[2*COORD_BITS +: ANGLE_BITS],
                  {(pfr_pkg::PhaseWidth-ANGLE_BITS){1'b0}}};
  assign z0_d  = {{2{phase[29]}}, phase[29:0]};
  assign q0_d  = pfr_pkg::quad_e'(phase[31:30] + 2'(phase[29]));

  // sideband that travels beside the cordic, index = stage
  logic                         act_q [NC+1];
  pfr_pkg::quad_e               quad_q[NC+1];
  logic signed [COORD_BITS-1:0] xa_q  [NC+1];
  logic signed [COORD_BITS-1:0] ya_q  [NC+1];
  logic signed [CW-1:0]         z0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      act_q[0]  <= s_axis_tuser;
      quad_q[0] <= q0_d;
      xa_q[0]   <= x_in;
      ya_q[0]   <= y_in;
      z0_q      <= z0_d;
    end
    for (int k = 1; k <= NC; k++) begin
      if (en[k]) begin
        act_q[k]  <= act_q[k-1];
        quad_q[k] <= quad_q[k-1];
        xa_q[k]   <= xa_q[k-1];
        ya_q[k]   <= ya_q[k-1];
      end
    end
  end

  // cordic chain, starting from (gain, 0) so the result is unit length
  logic signed [CW-1:0] cx[NC+1];
  logic signed [CW-1:0] cy[NC+1];
  logic signed [CW-1:0] cz[NC+1];

  assign cx[0] = pfr_pkg::CordicGain;
  assign cy[0] = '0;
  assign cz[0] = z0_q;

  for (genvar gi = 0; gi < NC; gi++) begin : g_cordic
    pfr_cordic_stage #(
      .STAGE (gi)
    ) u_stage (
      .clk_i (clk_i),
      .en_i  (en[gi+1]),
      .x_i   (cx[gi]),
      .y_i   (cy[gi]),
      .z_i   (cz[gi]),
      .x_o   (cx[gi+1]),
      .y_o   (cy[gi+1]),
      .z_o   (cz[gi+1])
    );
  end

  // map stage: quadrant rotation, then the transform direction
  logic signed [CW-1:0] cq, sq, s_dir, ns_dir;
  logic signed [CW-1:0] c_q, s_q, ns_q;
  logic signed [COORD_BITS-1:0] xm_q, ym_q;

  always_comb begin
    case (quad_q[NC])
      pfr_pkg::QUAD_0: begin cq = cx[NC];  sq = cy[NC];  end
      pfr_pkg::QUAD_1: begin cq = -cy[NC]; sq = cx[NC];  end
      pfr_pkg::QUAD_2: begin cq = -cx[NC]; sq = -cy[NC]; end
      pfr_pkg::QUAD_3: begin cq = cy[NC];  sq = -cx[NC]; end
      default:         begin cq = cx[NC];  sq = cy[NC];  end
    endcase
    // world to body turns by -heading, so the sine flips
    if (act_q[NC]) begin
      s_dir  = sq;
      ns_dir = -sq;
    end else begin
      s_dir  = -sq;
      ns_dir = sq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[MAP]) begin
      c_q  <= cq;
      s_q  <= s_dir;
      ns_q <= ns_dir;
      xm_q <= xa_q[NC];
      ym_q <= ya_q[NC];
    end
  end

  // x' = c*x - s*y, y' = s*x + c*y
  pfr_pkg::dot_en_t dot_en;
  logic signed [COORD_BITS-1:0] x_res, y_res;
  logic                         x_clip, y_clip;

  assign dot_en.mul = en[MUL];
  assign dot_en.add = en[ADD];
  assign dot_en.sat = en[SAT];

  pfr_dot #(
    .XW (COORD_BITS)
  ) u_dot_x (
    .clk_i  (clk_i),
    .en_i   (dot_en),
    .p_i    (c_q),
    .m_i    (ns_q),
    .a_i    (xm_q),
    .b_i    (ym_q),
    .res_o  (x_res),
    .clip_o (x_clip)
  );

  pfr_dot #(
    .XW (COORD_BITS)
  ) u_dot_y (
    .clk_i  (clk_i),
    .en_i   (dot_en),
    .p_i    (s_q),
    .m_i    (c_q),
    .a_i    (xm_q),
    .b_i    (ym_q),
    .res_o  (y_res),
    .clip_o (y_clip)
  );

  assign m_axis_tvalid = v_q[SAT];
  assign m_axis_tdata  = OUTW'({y_res, x_res});
  assign m_axis_tuser  = x_clip | y_clip;

  // an accepted beat always lands in the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v_q[0])
    else $error("accepted beat missing from input stage");

  // a clipped result carries a saturation bound in at least one coordinate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (x_res == MaxVal || x_res == MinVal || y_res == MaxVal || y_res == MinVal))
    else $error("clip flag without a saturated coordinate");

  // mapped cosine and sine stay within unit magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[MAP] |-> (c_q <= UnitBound && c_q >= -UnitBound &&
                  s_q <= UnitBound && s_q >= -UnitBound))
    else $error("cordic output out of unit range");

endmodule

FILE: hdl/pfr_cordic_stage.sv
// ----------------------------------------------------------------------------
// pfr_cordic_stage: one registered cordic micro-rotation
// rotates (x, y) by +/- atan(2^-STAGE) steered by the sign of z
// ----------------------------------------------------------------------------
module pfr_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic signed [pfr_pkg::CordicWidth-1:0]    x_i,
  input  logic signed [pfr_pkg::CordicWidth-1:0]    y_i,
  input  logic signed [pfr_pkg::CordicWidth-1:0]    z_i,
  output logic signed [pfr_pkg::CordicWidth-1:0]    x_o,
  output logic signed [pfr_pkg::CordicWidth-1:0]    y_o,
  output logic signed [pfr_pkg::CordicWidth-1:0]    z_o
);

  localparam logic signed [pfr_pkg::CordicWidth-1:0] Angle = pfr_pkg::atan_lut(5'(STAGE));

  logic signed [pfr_pkg::CordicWidth-1:0] x_sh, y_sh;
  logic signed [pfr_pkg::CordicWidth-1:0] x_d, y_d, z_d;
  logic signed [pfr_pkg::CordicWidth-1:0] x_q, y_q, z_q;

  // arithmetic shifts round toward minus infinity
  assign x_sh = x_i >>> STAGE;
  assign y_sh = y_i >>> STAGE;

  always_comb begin
    if (!z_i[pfr_pkg::CordicWidth-1]) begin
      x_d = x_i - y_sh;
      y_d = y_i + x_sh;
      z_d = z_i - Angle;
    end else begin
      x_d = x_i + y_sh;
      y_d = y_i - x_sh;
      z_d = z_i + Angle;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

FILE: hdl/pfr_dot.sv
// ----------------------------------------------------------------------------
// pfr_dot: (p*a + m*b) / 2^30 rounded half up, then saturated
// three stages: split products, partial sums, recombine and clamp
// ----------------------------------------------------------------------------
module pfr_dot #(
  parameter int XW = 32
) (
  input  logic                                   clk_i,
  input  pfr_pkg::dot_en_t                       en_i,
  input  logic signed [pfr_pkg::CordicWidth-1:0] p_i,
  input  logic signed [pfr_pkg::CordicWidth-1:0] m_i,
  input  logic signed [XW-1:0]                   a_i,
  input  logic signed [XW-1:0]                   b_i,
  output logic signed [XW-1:0]                   res_o,
  output logic                                   clip_o
);

  localparam int SB = pfr_pkg::SplitBits;
  localparam int CW = pfr_pkg::CordicWidth;
  localparam int EW = (XW > SB + 1) ? XW : SB + 1;
  localparam int HW = EW - SB;
  localparam int PLW = CW + SB + 1;
  localparam int PHW = CW + HW;
  localparam int LOW = PLW + 1;
  localparam int HIW = PHW + 1;
  localparam int TW  = HW + CW + 3;
  localparam logic signed [LOW-1:0] RoundHalf = LOW'(64'sd536870912);
  localparam logic signed [XW-1:0]  MaxVal = {1'b0, {(XW-1){1'b1}}};
  localparam logic signed [XW-1:0]  MinVal = {1'b1, {(XW-1){1'b0}}};

  logic signed [EW-1:0] a_e, b_e;
  logic signed [SB:0]   a_lo, b_lo;
  logic signed [HW-1:0] a_hi, b_hi;

  logic signed [PLW-1:0] pl_d, ml_d, pl_q, ml_q;
  logic signed [PHW-1:0] ph_d, mh_d, ph_q, mh_q;
  logic signed [LOW-1:0] lo_d, lo_q;
  logic signed [HIW-1:0] hi_d, hi_q;
  logic signed [TW-1:0]  t_sum, t_shr;
  logic                  in_range;
  logic signed [XW-1:0]  res_d, res_q;
  logic                  clip_d, clip_q;

  assign a_e  = EW'(a_i);
  assign b_e  = EW'(b_i);
  assign a_lo = {1'b0, a_e[SB-1:0]};
  assign b_lo = {1'b0, b_e[SB-1:0]};
  assign a_hi = a_e[EW-1:SB];
  assign b_hi = b_e[EW-1:SB];

  // split products, each at most 32 x 25 bits
  assign pl_d = p_i * a_lo;
  assign ml_d = m_i * b_lo;
  assign ph_d = p_i * a_hi;
  assign mh_d = m_i * b_hi;

  assign lo_d = LOW'(pl_q) + LOW'(ml_q) + RoundHalf;
  assign hi_d = HIW'(ph_q) + HIW'(mh_q);

  // recombine the halves and drop the q2.30 scale
  assign t_sum = TW'(hi_q) + TW'(lo_q >>> SB);
  assign t_shr = t_sum >>> (pfr_pkg::CordicWidth - 2 - SB);
  assign in_range = (&t_shr[TW-1:XW-1]) | ~(|t_shr[TW-1:XW-1]);

  always_comb begin
    if (in_range) begin
      res_d  = t_shr[XW-1:0];
      clip_d = 1'b0;
    end else begin
      res_d  = t_shr[TW-1] ? MinVal : MaxVal;
      clip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      pl_q <= pl_d;
      ml_q <= ml_d;
      ph_q <= ph_d;
      mh_q <= mh_d;
    end
    if (en_i.add) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (en_i.sat) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

FILE: sim/planar_frame_rotation_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_frame_rotation_check: beat checker for the planar frame rotator
// watches both stream channels, predicts every rotated point from the input
// beat and compares it field by field with the output beats in order
// ----------------------------------------------------------------------------
package planar_frame_rotation_tb_pkg;

  localparam int AngleBits = 16;
  localparam int CoordBits = 32;
  localparam int SDataW    = ((2*CoordBits+AngleBits+7)/8)*8;
  localparam int MDataW    = ((2*CoordBits+7)/8)*8;

  typedef enum bit {
    WORLD_TO_BODY = 1'b0,
    BODY_TO_WORLD = 1'b1
  } frame_dir_e;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic                 clipped;
  } rot_point_t;

endpackage

module planar_frame_rotation_check
  import pfr_pkg::*;
  import planar_frame_rotation_tb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  // x_in, y_in, heading
  input  logic [SDataW-1:0] s_axis_tdata,
  // action
  input  logic              s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // x_out, y_out
  input  logic [MDataW-1:0] m_axis_tdata,
  // clipped
  input  logic              m_axis_tuser,
  output int                mismatches_o,
  output int                owed_o
);

  // arctangent of 2^-i, full turn = 2^32
  localparam int unsigned ATAN_STEP [CordicStages] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1
  };

  localparam longint CoordMax = (64'sd1 <<< (CoordBits-1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;

  rot_point_t owed_points [$];
  rot_point_t want;
  int         fail_count;

  function automatic longint clamp_coord(input longint v, inout logic clip);
    if (v > CoordMax) begin
      clip = 1'b1;
      return CoordMax;
    end
    if (v < CoordMin) begin
      clip = 1'b1;
      return CoordMin;
    end
    return v;
  endfunction

  function automatic rot_point_t rotate_point(input frame_dir_e dir,
                                              input logic signed [CoordBits-1:0] px,
                                              input logic signed [CoordBits-1:0] py,
                                              input logic [AngleBits-1:0] hd);
    logic [PhaseWidth-1:0] phase;
    logic [1:0]            quad;
    logic [29:0]           resid;
    longint                z, cx, sy, nx, cs, sn, xr, yr;
    logic                  clip;
    rot_point_t            res;
    phase = PhaseWidth'(hd) << (PhaseWidth - AngleBits);
    quad  = phase[31:30];
    resid = phase[29:0];
    // fold the residual into [-1/8, 1/8) of a turn
    if (resid >= 30'h2000_0000) begin
      quad = quad + 2'd1;
      z    = longint'(resid) - 64'sh4000_0000;
    end else begin
      z = longint'(resid);
    end
    cx = longint'(CordicGain);
    sy = 0;
    for (int i = 0; i < CordicStages; i++) begin
      if (z >= 0) begin
        nx = cx - (sy >>> i);
        sy = sy + (cx >>> i);
        z  = z - longint'(ATAN_STEP[i]);
      end else begin
        nx = cx + (sy >>> i);
        sy = sy - (cx >>> i);
        z  = z + longint'(ATAN_STEP[i]);
      end
      cx = nx;
    end
    case (quad_e'(quad))
      QUAD_0:  begin cs = cx;  sn = sy;  end
      QUAD_1:  begin cs = -sy; sn = cx;  end
      QUAD_2:  begin cs = -cx; sn = -sy; end
      default: begin cs = sy;  sn = -cx; end
    endcase
    // world to body turns the other way
    if (dir == WORLD_TO_BODY) sn = -sn;
    // products stay below 2^62, so plain 64-bit math is exact
    xr   = (cs * longint'(px) - sn * longint'(py) + (64'sd1 <<< 29)) >>> 30;
    yr   = (sn * longint'(px) + cs * longint'(py) + (64'sd1 <<< 29)) >>> 30;
    clip = 1'b0;
    xr   = clamp_coord(xr, clip);
    yr   = clamp_coord(yr, clip);
    res.x       = xr[CoordBits-1:0];
    res.y       = yr[CoordBits-1:0];
    res.clipped = clip;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_points.delete();
      fail_count   = 0;
      mismatches_o <= 0;
      owed_o       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        // append the prediction at the tail of the queue
        owed_points = {owed_points,
                       rotate_point(frame_dir_e'(s_axis_tuser),
                                    s_axis_tdata[CoordBits-1:0],
                                    s_axis_tdata[2*CoordBits-1:CoordBits],
                                    s_axis_tdata[2*CoordBits+AngleBits-1:2*CoordBits])};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_points.size() == 0) begin
          fail_count++;
          $display("%0t: output beat with nothing pending, expected none, got x %0d y %0d clip %0b",
                   $time, $signed(m_axis_tdata[CoordBits-1:0]),
                   $signed(m_axis_tdata[2*CoordBits-1:CoordBits]), m_axis_tuser);
        end else begin
          want = owed_points.pop_front();
          if (m_axis_tdata[CoordBits-1:0] !== want.x) begin
            fail_count++;
            $display("%0t: x_out mismatch, expected %0d, got %0d", $time,
                     $signed(want.x), $signed(m_axis_tdata[CoordBits-1:0]));
          end
          if (m_axis_tdata[2*CoordBits-1:CoordBits] !== want.y) begin
            fail_count++;
            $display("%0t: y_out mismatch, expected %0d, got %0d", $time,
                     $signed(want.y), $signed(m_axis_tdata[2*CoordBits-1:CoordBits]));
          end
          if (m_axis_tuser !== want.clipped) begin
            fail_count++;
            $display("%0t: clipped mismatch, expected %0b, got %0b", $time,
                     want.clipped, m_axis_tuser);
          end
        end
      end
      mismatches_o <= fail_count;
      owed_o       <= owed_points.size();
    end
  end

endmodule

FILE: sim/planar_frame_rotation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_frame_rotation_test: stimulus and verdict for the planar frame rotator
// directed corner points, then random points under several idle and stall
// mixes, one long output hold-off and drains between phases
// ----------------------------------------------------------------------------
module planar_frame_rotation_test;
  import pfr_pkg::*;
  import planar_frame_rotation_tb_pkg::*;

  // cycles without any accepted beat before the run is declared hung
  localparam int HangLimit = 4000;
  // output hold-off long enough to fill every pipeline stage
  localparam int HoldCycles = 300;

  localparam logic [CoordBits-1:0] CMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic [CoordBits-1:0] CMin = {1'b1, {(CoordBits-1){1'b0}}};

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  // x_in, y_in, heading
  logic [SDataW-1:0] s_axis_tdata;
  // action
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // x_out, y_out
  logic [MDataW-1:0] m_axis_tdata;
  // clipped
  logic              m_axis_tuser;

  int mismatch_count;
  int points_owed;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_left;

  planar_frame_rotation dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  planar_frame_rotation_check checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .mismatches_o (mismatch_count),
    .owed_o       (points_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // hang detector: any accepted beat on either side resets the count
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < HangLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("planar_frame_rotation test failed");
    $finish;
  end

  // one input beat, preceded by random idle cycles; returns at the accepting edge
  task automatic send_point(input frame_dir_e dir, input logic [CoordBits-1:0] px,
                            input logic [CoordBits-1:0] py, input logic [AngleBits-1:0] hd);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= SDataW'({hd, py, px});
    s_axis_tuser  <= dir;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_both_ways(input logic [CoordBits-1:0] px, input logic [CoordBits-1:0] py,
                                input logic [AngleBits-1:0] hd);
    send_point(WORLD_TO_BODY, px, py, hd);
    send_point(BODY_TO_WORLD, px, py, hd);
  endtask

  // stop offering and wait until every predicted point has come back
  task automatic drain_points();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (points_owed != 0);
  endtask

  // full-range values half of the time, plus small, mid-size and extreme ones
  function automatic logic [CoordBits-1:0] pick_coord();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 5))
      0, 1, 2: return r;
      3:       return {{12{r[19]}}, r[19:0]};
      4: begin
        case ($urandom_range(0, 3))
          0:       return CMax;
          1:       return CMin;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return {{8{r[23]}}, r[23:0]};
    endcase
  endfunction

  // octant boundaries exercise the quadrant fold
  function automatic logic [AngleBits-1:0] pick_heading();
    if ($urandom_range(0, 3) != 0) return AngleBits'($urandom());
    return {3'($urandom_range(0, 7)), 13'd0} + 16'($urandom_range(0, 2)) - 16'd1;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_point(frame_dir_e'($urandom() & 1), pick_coord(), pick_coord(),
                              pick_heading());
  endtask

  initial begin
    int src_mix [4];
    int sink_mix [4];
    src_mix  = '{0, 51, 0, 31};
    sink_mix = '{0, 0, 51, 31};
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners, each in both directions
    send_both_ways(CMax, CMin, 16'h0000);             // identity, extremes pass through
    send_both_ways(CMin, CMin, 16'h4000);             // quarter turn of the minimum clips
    send_both_ways(CMin, CMax, 16'h8000);             // half turn, negated minimum clips
    send_both_ways(CMax, CMax, 16'h2000);             // eighth turn, fold boundary, clips
    send_both_ways(32'h0001_0000, '0, 16'h1FFF);      // just below the fold
    send_both_ways('1, 32'd1, 16'hFFFF);              // tiny values, rounding half up
    send_both_ways('0, '0, 16'h7FFF);                 // origin stays put
    send_both_ways(32'h0001_8000, 32'hFFFE_8000, 16'h6000); // fold inside quadrant one
    send_both_ways(32'd1, '1, 16'hE000);
    send_both_ways(32'h5555_5555, 32'hAAAA_AAAA, 16'hA5A5);
    send_both_ways(32'hAAAA_AAAA, 32'h5555_5555, 16'h5A5A);
    drain_points();

    // random points under each idle and stall mix, drained between phases
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_mix[p];
      sink_stall_pct = sink_mix[p];
      send_random(130);
      drain_points();
    end

    // long hold-off on the output while the input keeps offering beats
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = HoldCycles;
    send_random(90);
    drain_points();

    // let any stray beats show up before the verdict
    repeat (2 * PipeDepth + 10) @(posedge clk_i);
    if (mismatch_count == 0 && points_owed == 0) begin
      $display("planar_frame_rotation test passed");
    end else begin
      $display("planar_frame_rotation test failed");
    end
    $finish;
  end

endmodule
